@@ rtl/mmnt_pkg.sv @@
`timescale 1ns / 1ps

package mmnt_pkg;

	localparam int NOTE_W      = 7;
	localparam int VEL_W       = 7;
	localparam int CMD_W       = 2;
	localparam int CHAN_W      = 4;
	localparam int SEL_W       = 5;
	localparam int NOTE_COUNT  = 128;

	// Search tree: groups of eight map bits, one level of groups.
	localparam int GRP_SIZE    = 8;
	localparam int GRP_COUNT   = NOTE_COUNT / GRP_SIZE;
	localparam int GRP_IDX_W   = $clog2(GRP_SIZE);
	localparam int GRP_SEL_W   = $clog2(GRP_COUNT);

	localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BEND     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_OTHER    = 2'd3;

	localparam logic [NOTE_W-1:0] NOTE_RESET     = 7'd60;
	localparam logic [VEL_W-1:0]  VELOCITY_RESET = 7'd102;
	localparam logic [SEL_W-1:0]  SEL_OMNI       = 5'd0;
	localparam logic [SEL_W-1:0]  SEL_MAX        = 5'd16;

	typedef struct packed {
		logic load;   // take the input transaction, apply the map update
		logic enc;    // finish the highest-note search
		logic push;   // copy the state into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic rel_hit;   // offered item is a release that passes the filters
		logic out_free;  // output register can take a result this cycle
	} dp_stat_t;

endpackage

@@ rtl/mmnt_if.sv @@
`timescale 1ns / 1ps

interface mmnt_in_if;
	logic                          valid;
	logic                          ready;
	logic [mmnt_pkg::CMD_W-1:0]    command;
	logic [mmnt_pkg::CHAN_W-1:0]   msg_channel;
	logic [mmnt_pkg::NOTE_W-1:0]   note_number;
	logic [mmnt_pkg::VEL_W-1:0]    velocity_in;

	modport source (output valid, command, msg_channel, note_number, velocity_in,
		input ready);
	modport sink (input valid, command, msg_channel, note_number, velocity_in,
		output ready);
endinterface

interface mmnt_out_if;
	logic                          valid;
	logic                          ready;
	logic [mmnt_pkg::NOTE_W-1:0]   active_note;
	logic [mmnt_pkg::VEL_W-1:0]    active_velocity;
	logic                          gate_out;

	modport source (output valid, active_note, active_velocity, gate_out,
		input ready);
	modport sink (input valid, active_note, active_velocity, gate_out,
		output ready);
endinterface

@@ rtl/mmnt_ctrl.sv @@
`timescale 1ns / 1ps

module mmnt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mmnt_pkg::dp_stat_t stat,
	output mmnt_pkg::dp_cmd_t  cmd
);
	import mmnt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ENC  = 2'd1;
	localparam logic [1:0] S_PUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.rel_hit ? S_ENC : S_PUSH;
				end
			end
			S_ENC: begin
				cmd.enc = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/mmnt_dp.sv @@
`timescale 1ns / 1ps

module mmnt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mmnt_pkg::SEL_W-1:0]    cfg_wdata,
	input  logic [mmnt_pkg::CMD_W-1:0]    command,
	input  logic [mmnt_pkg::CHAN_W-1:0]   msg_channel,
	input  logic [mmnt_pkg::NOTE_W-1:0]   note_number,
	input  logic [mmnt_pkg::VEL_W-1:0]    velocity_in,
	input  mmnt_pkg::dp_cmd_t             cmd,
	output mmnt_pkg::dp_stat_t            stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mmnt_pkg::NOTE_W-1:0]   active_note,
	output logic [mmnt_pkg::VEL_W-1:0]    active_velocity,
	output logic                          gate_out
);
	import mmnt_pkg::*;

	logic [SEL_W-1:0]      chan_sel_q;
	logic [NOTE_COUNT-1:0] held_q;
	logic [NOTE_COUNT-1:0] held_next;
	logic [NOTE_W-1:0]     note_q;
	logic [VEL_W-1:0]      vel_q;
	logic                  gate_q;

	logic                  chan_ok;
	logic                  note_ok;
	logic                  on_hit;
	logic                  rel_hit;

	logic [GRP_COUNT-1:0]  grp_any_d;
	logic [GRP_IDX_W-1:0]  grp_idx_d [GRP_COUNT];
	logic [GRP_COUNT-1:0]  grp_any_s1;
	logic [GRP_IDX_W-1:0]  grp_idx_s1 [GRP_COUNT];

	logic                  top_any;
	logic [NOTE_W-1:0]     top_note;

	logic                  out_valid_q;
	logic [NOTE_W-1:0]     out_note_q;
	logic [VEL_W-1:0]      out_vel_q;
	logic                  out_gate_q;

	// Message filter and decode
	always_comb begin
		chan_ok = (chan_sel_q == SEL_OMNI) ||
			((chan_sel_q <= SEL_MAX) &&
			({1'b0, msg_channel} == (chan_sel_q - SEL_W'(1))));
		note_ok = ({1'b0, note_number} < (NOTE_W + 1)'(NOTE_COUNT));
		on_hit  = chan_ok && note_ok && (command == CMD_NOTE_ON) && (velocity_in != '0);
		rel_hit = chan_ok && note_ok && !on_hit &&
			(command inside {CMD_NOTE_ON, CMD_NOTE_OFF});
	end

	always_comb begin
		held_next = held_q;
		if (on_hit) begin
			held_next[note_number] = 1'b1;
		end else if (rel_hit) begin
			held_next[note_number] = 1'b0;
		end
	end

	// First level of the search: highest set bit inside each group
	always_comb begin
		for (int g = 0; g < GRP_COUNT; g++) begin
			grp_any_d[g] = |held_next[g*GRP_SIZE +: GRP_SIZE];
			grp_idx_d[g] = '0;
			for (int b = 0; b < GRP_SIZE; b++) begin
				if (held_next[g*GRP_SIZE + b]) begin
					grp_idx_d[g] = GRP_IDX_W'(b);
				end
			end
		end
	end

	// Second level: highest group with a held note
	always_comb begin
		top_any  = |grp_any_s1;
		top_note = '0;
		for (int g = 0; g < GRP_COUNT; g++) begin
			if (grp_any_s1[g]) begin
				top_note = {GRP_SEL_W'(g), grp_idx_s1[g]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			grp_any_s1 <= grp_any_d;
			grp_idx_s1 <= grp_idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_sel_q <= SEL_OMNI;
			held_q     <= '0;
			note_q     <= NOTE_RESET;
			vel_q      <= VELOCITY_RESET;
			gate_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				chan_sel_q <= cfg_wdata;
			end
			if (cmd.load) begin
				held_q <= held_next;
				if (on_hit) begin
					note_q <= note_number;
					vel_q  <= velocity_in;
					gate_q <= 1'b1;
				end
			end
			if (cmd.enc) begin
				gate_q <= top_any;
				if (top_any) begin
					note_q <= top_note;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_note_q <= note_q;
			out_vel_q  <= vel_q;
			out_gate_q <= gate_q;
		end
	end

	assign stat.rel_hit     = rel_hit;
	assign stat.out_free    = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign active_note      = out_note_q;
	assign active_velocity  = out_vel_q;
	assign gate_out         = out_gate_q;

endmodule

@@ rtl/mono_midi_note_tracker_top.sv @@
`timescale 1ns / 1ps

// Channel      Dir  Handshake      Payload
// in_ch        in   valid/ready    command, msg_channel, note_number, velocity_in
// out_ch       out  valid/ready    active_note, active_velocity, gate_out
// cfg          in   cfg_we         cfg_wdata = channel_select
//
// A note-on, a filtered-out message or any non-note message goes from accept to
// push; a release adds a search state, as the highest-note search is a two-level
// tree (groups of eight, then the group pick) with a register between the levels.
// One result per input transaction; the next input is taken while a result waits
// in the output register, and the block holds in its push state if that register
// is still full. Reset clears the held-note map, note 60, velocity 102, gate low.
module mono_midi_note_tracker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mmnt_pkg::SEL_W-1:0]  cfg_wdata,
	mmnt_in_if.sink                     in_ch,
	mmnt_out_if.source                  out_ch
);
	import mmnt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer: accept, optional search step, push result
	mmnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Held-note map, voice state, search tree and output register
	mmnt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.command         (in_ch.command),
		.msg_channel     (in_ch.msg_channel),
		.note_number     (in_ch.note_number),
		.velocity_in     (in_ch.velocity_in),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.active_note     (out_ch.active_note),
		.active_velocity (out_ch.active_velocity),
		.gate_out        (out_ch.gate_out)
	);

endmodule
